/* src/rmq_pkg.sv */
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;
    localparam int TERM_W        = 17;   // magnitude of a sum of two entries
    localparam int OUT_W         = 16;

    typedef enum logic [1:0] {
        LEAD_W = 2'd0,
        LEAD_X = 2'd1,
        LEAD_Y = 2'd2,
        LEAD_Z = 2'd3
    } t_lead;

    // per-item data that rides alongside the square root
    typedef struct packed {
        t_lead                   lead;
        logic [2:0]              neg;
        logic [2:0][TERM_W-1:0]  mag;
    } t_side;

endpackage

/* src/rmq_sqrt.sv */
`timescale 1ns / 1ps
module rmq_sqrt #(
    parameter int XW  = 48,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [XW-1:0]     i_rad,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [XW/2-1:0]   o_root,
    output logic [SBW-1:0]    o_side
);
    localparam int RB = XW / 2;
    localparam int RW = RB + 2;

    logic [XW-1:0]  r_x    [RB];
    logic [RW-1:0]  r_rem  [RB];
    logic [RB-1:0]  r_q    [RB];
    logic [SBW-1:0] r_side [RB];
    logic [RB-1:0]  r_valid;

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [XW-1:0]  src_x;
        logic [RW-1:0]  src_rem;
        logic [RB-1:0]  src_q;
        logic [SBW-1:0] src_side;
        logic           src_valid;
        logic [RW-1:0]  cat;
        logic [RW-1:0]  trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign src_x     = i_rad;
            assign src_rem   = '0;
            assign src_q     = '0;
            assign src_side  = i_side;
            assign src_valid = i_valid;
        end else begin : g_next
            assign src_x     = r_x[k-1];
            assign src_rem   = r_rem[k-1];
            assign src_q     = r_q[k-1];
            assign src_side  = r_side[k-1];
            assign src_valid = r_valid[k-1];
        end

        // bring down two radicand bits, try (2q)*2+1
        assign cat   = {src_rem[RW-3:0], src_x[XW-1 -: 2]};
        assign trial = {src_q, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= src_valid;
            end
            if (i_en) begin
                r_x[k]    <= src_x << 2;
                r_rem[k]  <= ge ? (cat - trial) : cat;
                r_q[k]    <= {src_q[RB-2:0], ge};
                r_side[k] <= src_side;
            end
        end
    end

    assign o_valid = r_valid[RB-1];
    assign o_root  = r_q[RB-1];
    assign o_side  = r_side[RB-1];

endmodule

/* src/rmq_div.sv */
`timescale 1ns / 1ps
module rmq_div #(
    parameter int NW = 17,
    parameter int DW = 25,
    parameter int QB = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);
    // dividend is i_num scaled by 2^(QB-1); quotient assumed below 2^QB
    localparam int RW = NW + QB - 1;
    localparam int CW = RW + DW;

    logic [RW-1:0] r_rem [QB];
    logic [QB-1:0] r_q   [QB];
    logic [DW-1:0] r_den [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int POS = QB - 1 - k;
        logic [RW-1:0] src_rem;
        logic [QB-1:0] src_q;
        logic [DW-1:0] src_den;
        logic [CW-1:0] shf;
        logic          ge;

        if (k == 0) begin : g_first
            assign src_rem = RW'(i_num) << (QB - 1);
            assign src_q   = '0;
            assign src_den = i_den;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_q   = r_q[k-1];
            assign src_den = r_den[k-1];
        end

        assign shf = CW'(src_den) << POS;
        assign ge  = (CW'(src_rem) >= shf);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (src_rem - RW'(shf)) : src_rem;
                r_q[k]   <= {src_q[QB-2:0], ge};
                r_den[k] <= src_den;
            end
        end
    end

    assign o_quo = r_q[QB-1];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps
// rotation matrix to quaternion, four-branch trace method
// input channel: i_valid / o_stall with the nine entries m00..m22 (signed,
//   FRAC_BITS fraction bits); a request is taken when i_valid is high and
//   o_stall is low
// output channel: o_valid / i_stall with qw qx qy qz (signed, same format,
//   saturated to +-1.0 and to 16 bits); taken when o_valid high, i_stall low
// stages: an input register, the FRAC_BITS+10 root stages, the FRAC_BITS+1
//   divider stages and an output register
// throughput: one request per cycle unless the pipe stalls; every stage advances together
// stall: while a result waits under i_stall the whole pipe holds, o_stall
//   rises and nothing is lost or repeated; bubbles keep moving otherwise
// reset: synchronous, active low, empties the pipe; no other state exists
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [IN_W-1:0]  i_m00,
    input  logic signed [IN_W-1:0]  i_m01,
    input  logic signed [IN_W-1:0]  i_m02,
    input  logic signed [IN_W-1:0]  i_m10,
    input  logic signed [IN_W-1:0]  i_m11,
    input  logic signed [IN_W-1:0]  i_m12,
    input  logic signed [IN_W-1:0]  i_m20,
    input  logic signed [IN_W-1:0]  i_m21,
    input  logic signed [IN_W-1:0]  i_m22,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_qw,
    output logic signed [OUT_W-1:0] o_qx,
    output logic signed [OUT_W-1:0] o_qy,
    output logic signed [OUT_W-1:0] o_qz
);
    localparam int RADW = FRAC_BITS + 21;          // signed radicand
    localparam int XW   = 2 * FRAC_BITS + 20;      // radicand scaled by ONE
    localparam int RB   = XW / 2;                  // root bits
    localparam int DW   = RB + 1;                  // divisor 2r
    localparam int QB   = FRAC_BITS + 1;           // quotient bits kept
    localparam int MW   = FRAC_BITS + 2;           // clamp width
    localparam int CW   = RB + TERM_W + 2;         // saturation compare
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint CAPP_L = (ONE_L < 32767) ? ONE_L : 32767;
    localparam longint CAPN_L = (ONE_L < 32768) ? ONE_L : 32768;
    localparam logic [MW-1:0] CAPP = MW'(CAPP_L);
    localparam logic [MW-1:0] CAPN = MW'(CAPN_L);
    localparam logic signed [RADW-1:0] ONE_R = RADW'(ONE_L);

    // the whole pipe moves unless a finished result is held
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // ---------------- stage 1: branch pick, radicand, off-diagonal terms
    logic signed [IN_W+1:0]   tr;
    logic signed [TERM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
    logic signed [TERM_W-1:0] ta, tb, tc;
    logic signed [RADW-1:0]   s_rad;
    logic [RADW-2:0]          rad_u;
    t_lead                    n_lead;
    t_side                    n_side;

    assign tr     = (IN_W+2)'(i_m00) + (IN_W+2)'(i_m11) + (IN_W+2)'(i_m22);
    assign d21_12 = TERM_W'(i_m21) - TERM_W'(i_m12);
    assign d02_20 = TERM_W'(i_m02) - TERM_W'(i_m20);
    assign d10_01 = TERM_W'(i_m10) - TERM_W'(i_m01);
    assign s01_10 = TERM_W'(i_m01) + TERM_W'(i_m10);
    assign s02_20 = TERM_W'(i_m02) + TERM_W'(i_m20);
    assign s12_21 = TERM_W'(i_m12) + TERM_W'(i_m21);

    always_comb begin
        if (tr > 0) begin
            n_lead = LEAD_W;
            s_rad  = ONE_R + RADW'(tr);
            ta = d21_12; tb = d02_20; tc = d10_01;
        end else if (i_m00 > i_m11 && i_m00 > i_m22) begin
            n_lead = LEAD_X;
            s_rad  = ONE_R + RADW'(i_m00) - RADW'(i_m11) - RADW'(i_m22);
            ta = d21_12; tb = s01_10; tc = s02_20;
        end else if (i_m11 > i_m22) begin
            n_lead = LEAD_Y;
            s_rad  = ONE_R + RADW'(i_m11) - RADW'(i_m00) - RADW'(i_m22);
            ta = d02_20; tb = s01_10; tc = s12_21;
        end else begin
            n_lead = LEAD_Z;
            s_rad  = ONE_R + RADW'(i_m22) - RADW'(i_m00) - RADW'(i_m11);
            ta = d10_01; tb = s02_20; tc = s12_21;
        end
    end

    // negative radicand clamps to zero
    assign rad_u = s_rad[RADW-1] ? '0 : s_rad[RADW-2:0];

    // terms travel as sign and magnitude so the divider stays unsigned
    always_comb begin
        n_side.lead   = n_lead;
        n_side.neg    = {tc[TERM_W-1], tb[TERM_W-1], ta[TERM_W-1]};
        n_side.mag[0] = ta[TERM_W-1] ? -ta : ta;
        n_side.mag[1] = tb[TERM_W-1] ? -tb : tb;
        n_side.mag[2] = tc[TERM_W-1] ? -tc : tc;
    end

    logic          r1_valid;
    logic [XW-1:0] r1_x;
    t_side         r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_valid;
        end
        if (adv) begin
            r1_x    <= {rad_u[XW-FRAC_BITS-1:0], FRAC_BITS'(0)};
            r1_side <= n_side;
        end
    end

    // ---------------- square root, one result bit per stage
    logic           sq_valid;
    logic [RB-1:0]  sq_root;
    t_side          sq_side;
    logic [$bits(t_side)-1:0] sq_side_in;
    logic [$bits(t_side)-1:0] sq_side_bits;

    assign sq_side_in = r1_side;
    assign sq_side    = t_side'(sq_side_bits);

    rmq_sqrt #(
        .XW  (XW),
        .SBW ($bits(t_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r1_valid),
        .i_rad   (r1_x),
        .i_side  (sq_side_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    // ---------------- divide each term by 2r; a quotient of 2 or more saturates
    logic [DW-1:0] den;
    logic [QB-1:0] quo [3];
    logic [2:0]    n_sat;

    assign den = {sq_root, 1'b0};

    for (genvar c = 0; c < 3; c++) begin : g_lane
        // term*ONE/D reaches 2*ONE exactly when term >= 2*D
        assign n_sat[c] = (CW'(sq_side.mag[c]) >= (CW'(den) << 1));

        rmq_div #(
            .NW (TERM_W),
            .DW (DW),
            .QB (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (sq_side.mag[c]),
            .i_den (den),
            .o_quo (quo[c])
        );
    end

    // sideband delay matching the divider
    typedef struct packed {
        logic          valid;
        t_lead         lead;
        logic [2:0]    neg;
        logic [2:0]    sat;
        logic          zero;
        logic [RB-1:0] half;
    } t_dly;

    t_dly r_dly [QB];
    t_dly n_dly;

    always_comb begin
        n_dly.valid = sq_valid;
        n_dly.lead  = sq_side.lead;
        n_dly.neg   = sq_side.neg;
        n_dly.sat   = n_sat;
        n_dly.zero  = (sq_root == '0);
        n_dly.half  = sq_root >> 1;
    end

    for (genvar k = 0; k < QB; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly[k].valid <= 1'b0;
            end else if (adv) begin
                r_dly[k].valid <= (k == 0) ? n_dly.valid : r_dly[(k == 0) ? 0 : k-1].valid;
            end
            if (adv) begin
                if (k == 0) begin
                    r_dly[k].lead <= n_dly.lead;
                    r_dly[k].neg  <= n_dly.neg;
                    r_dly[k].sat  <= n_dly.sat;
                    r_dly[k].zero <= n_dly.zero;
                    r_dly[k].half <= n_dly.half;
                end else begin
                    r_dly[k].lead <= r_dly[(k == 0) ? 0 : k-1].lead;
                    r_dly[k].neg  <= r_dly[(k == 0) ? 0 : k-1].neg;
                    r_dly[k].sat  <= r_dly[(k == 0) ? 0 : k-1].sat;
                    r_dly[k].zero <= r_dly[(k == 0) ? 0 : k-1].zero;
                    r_dly[k].half <= r_dly[(k == 0) ? 0 : k-1].half;
                end
            end
        end
    end

    // ---------------- output stage: clamp, sign, slot placement
    t_dly                    tl;
    logic [MW-1:0]           mag_c [3];
    logic signed [OUT_W-1:0] oth   [3];
    logic signed [OUT_W-1:0] lead_v;
    logic [MW-1:0]           half_m;
    logic signed [OUT_W-1:0] n_q   [4];

    assign tl = r_dly[QB-1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (tl.zero) begin
                mag_c[c] = '0;
            end else if (tl.sat[c]) begin
                mag_c[c] = MW'(ONE_L) << 1;
            end else begin
                mag_c[c] = MW'(quo[c]);
            end
            if (tl.neg[c]) begin
                oth[c] = -OUT_W'((mag_c[c] > CAPN) ? CAPN : mag_c[c]);
            end else begin
                oth[c] = OUT_W'((mag_c[c] > CAPP) ? CAPP : mag_c[c]);
            end
        end
        half_m = ((RB + 1)'(tl.half) > (RB + 1)'(CAPP)) ? CAPP : MW'(tl.half);
        lead_v = OUT_W'(half_m);
        for (int k = 0; k < 4; k++) begin
            if (2'(k) == tl.lead) begin
                n_q[k] = lead_v;
            end else if (2'(k) < tl.lead) begin
                n_q[k] = oth[k];
            end else begin
                n_q[k] = oth[(k == 0) ? 0 : k-1];
            end
        end
    end

    logic                    r_ov;
    logic signed [OUT_W-1:0] r_q [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= tl.valid;
        end
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_q[k] <= n_q[k];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_qw    = r_q[0];
    assign o_qx    = r_q[1];
    assign o_qy    = r_q[2];
    assign o_qz    = r_q[3];

    // ---------------- checks
    a_qw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_qw <= $signed(OUT_W'(CAPP)) && o_qw >= -$signed(17'(CAPN))))
        else $error("qw outside unit range");

    a_lead_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && tl.valid) |-> !lead_v[OUT_W-1])
        else $error("lead component negative");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input held while output empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule
